### hdl/sitoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_pkg - shared definitions for the signed integer to decimal text block
// Widths, character codes and the result type passed from the conversion
// unit to the character sequencer.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    // Width of the two's complement input value
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
    // (log10(2) ~ 0.30103)
    localparam int DIGITS   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_BITS = DIGITS * 4;

    // Step counter holds VALUE_BITS itself
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
    localparam int IDX_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // ASCII codes
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;

    // Shift-and-add-3 correction
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    // Finished conversion: sign and packed BCD digits, least significant low
    typedef struct packed {
        logic                negative;
        logic [BCD_BITS-1:0] bcd;
    } t_conv_res;

endpackage

### hdl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii - signed integer to decimal ASCII text
// A request is taken when start is high and busy low. The block then sends
// the value's text one character per cycle on o_char_code, each marked by a
// one-cycle o_strobe, with o_is_last on the final character; the receiver
// must take every character as it comes. A negative value opens with '-',
// digits follow most significant first without leading zeros, and zero
// gives a single '0'. While a request keeps busy high, the bit-serial
// binary to BCD loop takes one magnitude bit per cycle, the digits are then
// handed to the sequencer, and the sequencer sends one character per cycle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic [sitoa_pkg::VALUE_BITS-1:0]    i_value,
    output logic                                busy,
    output logic                                o_strobe,
    output logic [7:0]                          o_char_code,
    output logic                                o_is_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]            r_state, n_state;
    logic                  w_accept;
    logic                  w_conv_done;
    sitoa_pkg::t_conv_res  w_conv_res;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // Binary to BCD conversion
    sitoa_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (i_value),
        .o_done  (w_conv_done),
        .o_res   (w_conv_res)
    );

    // Character output
    sitoa_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_conv_done),
        .i_res       (w_conv_res),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

    // Request sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CONV;
            end
            S_CONV: begin
                if (w_conv_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (o_strobe && o_is_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/sitoa_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_dabble - bit-serial binary to BCD converter
// Takes the magnitude of the signed input and runs one shift-and-add-3 step
// per cycle, one magnitude bit each, to build the packed decimal digits.
// ----------------------------------------------------------------------------
module sitoa_dabble (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [sitoa_pkg::VALUE_BITS-1:0]    i_value,
    output logic                                o_done,
    output sitoa_pkg::t_conv_res                o_res
);

    logic                                 r_run,  n_run;
    logic                                 r_done, n_done;
    logic [sitoa_pkg::CNT_BITS-1:0]       r_cnt,  n_cnt;
    logic [sitoa_pkg::VALUE_BITS-1:0]     r_mag,  n_mag;
    logic [sitoa_pkg::BCD_BITS-1:0]       r_bcd,  n_bcd;
    logic                                 r_neg,  n_neg;

    logic [sitoa_pkg::BCD_BITS-1:0]       w_adj;
    logic [sitoa_pkg::VALUE_BITS-1:0]     w_abs;

    // Magnitude of the request; the most negative value maps to 2^(N-1)
    assign w_abs = i_value[sitoa_pkg::VALUE_BITS-1]
                 ? (~i_value + {{(sitoa_pkg::VALUE_BITS-1){1'b0}}, 1'b1})
                 : i_value;

    // Add 3 to every digit of 5 or more ahead of the shift
    always_comb begin
        w_adj = r_bcd;
        for (int d = 0; d < sitoa_pkg::DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= sitoa_pkg::BCD_ADJ_MIN) begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + sitoa_pkg::BCD_ADJ;
            end
        end
    end

    // Sequencer and datapath next state
    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_neg  = r_neg;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = sitoa_pkg::CNT_BITS'(sitoa_pkg::VALUE_BITS);
            n_mag = w_abs;
            n_bcd = '0;
            n_neg = i_value[sitoa_pkg::VALUE_BITS-1];
        end else if (r_run) begin
            n_bcd = {w_adj[sitoa_pkg::BCD_BITS-2:0], r_mag[sitoa_pkg::VALUE_BITS-1]};
            n_mag = {r_mag[sitoa_pkg::VALUE_BITS-2:0], 1'b0};
            n_cnt = r_cnt - sitoa_pkg::CNT_BITS'(1);
            if (r_cnt == sitoa_pkg::CNT_BITS'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign o_done         = r_done;
    assign o_res.negative = r_neg;
    assign o_res.bcd      = r_bcd;

endmodule

### hdl/sitoa_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_emit - character sequencer
// Sends the optional minus sign, then the digits from the leading non-zero
// one down to the units, one registered character per cycle.
// ----------------------------------------------------------------------------
module sitoa_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sitoa_pkg::t_conv_res  i_res,
    output logic                  o_strobe,
    output logic [7:0]            o_char_code,
    output logic                  o_is_last
);

    logic                              r_run,    n_run;
    logic                              r_neg,    n_neg;
    logic [sitoa_pkg::IDX_BITS-1:0]    r_idx,    n_idx;
    logic [sitoa_pkg::BCD_BITS-1:0]    r_bcd,    n_bcd;
    logic                              r_strobe, n_strobe;
    logic [7:0]                        r_char,   n_char;
    logic                              r_last,   n_last;

    logic [sitoa_pkg::IDX_BITS-1:0]    w_top;
    logic [3:0]                        w_digit;

    // Leading non-zero digit; zero gives the units digit
    always_comb begin
        w_top = '0;
        for (int d = 0; d < sitoa_pkg::DIGITS; d++) begin
            if (i_res.bcd[d*4 +: 4] != 4'd0) begin
                w_top = sitoa_pkg::IDX_BITS'(d);
            end
        end
    end

    assign w_digit = r_bcd[{r_idx, 2'b00} +: 4];

    // One character per cycle while running
    always_comb begin
        n_run    = r_run;
        n_neg    = r_neg;
        n_idx    = r_idx;
        n_bcd    = r_bcd;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = 1'b0;
        if (i_load) begin
            n_run = 1'b1;
            n_neg = i_res.negative;
            n_idx = w_top;
            n_bcd = i_res.bcd;
        end else if (r_run) begin
            n_strobe = 1'b1;
            if (r_neg) begin
                n_char = sitoa_pkg::CH_MINUS;
                n_neg  = 1'b0;
            end else begin
                n_char = sitoa_pkg::CH_ZERO + {4'b0000, w_digit};
                if (r_idx == '0) begin
                    n_last = 1'b1;
                    n_run  = 1'b0;
                end else begin
                    n_idx = r_idx - sitoa_pkg::IDX_BITS'(1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_run    <= n_run;
            r_strobe <= n_strobe;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_idx  <= n_idx;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;

endmodule

### hdl/sitoa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_checker - port-level checks for the decimal text block
// Watches the request and character ports and is bound to the top level.
// ----------------------------------------------------------------------------
module sitoa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_strobe,
    input logic [7:0]                          o_char_code,
    input logic                                o_is_last
);

    // Only a minus sign or a decimal digit is ever sent
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_char_code == sitoa_pkg::CH_MINUS) ||
                     ((o_char_code >= sitoa_pkg::CH_ZERO) &&
                      (o_char_code <= (sitoa_pkg::CH_ZERO + 8'd9))))
        else $error("character outside the sign and digit set");

    // A minus sign is never last and a digit follows it straight away
    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_char_code == sitoa_pkg::CH_MINUS)) |->
        !o_is_last ##1 (o_strobe && (o_char_code != sitoa_pkg::CH_MINUS)))
        else $error("minus sign not followed by a digit");

    // Characters only while a request is in progress
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("character sent while idle");

    // A taken request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // The block only goes idle after the last character
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> $past(o_strobe && o_is_last))
        else $error("request ended without a last character");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_char_code (o_char_code),
    .o_is_last   (o_is_last)
);
